// ===== sv/modular_inverse_ext_euclid_macros.svh =====
// assertion macros for the modular inverse block
// used by the top level, no other dependencies
`ifndef MODULAR_INVERSE_EXT_EUCLID_MACROS_SVH
`define MODULAR_INVERSE_EXT_EUCLID_MACROS_SVH

// same-cycle implication, disabled in reset
`define MIE_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("mie assertion failed");

// next-cycle implication, disabled in reset
`define MIE_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("mie assertion failed");

`endif

// ===== sv/mie_pkg.sv =====
// shared types for the modular inverse block
// controller states and the command / status structs between controller and datapath
package mie_pkg;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_ITER,
      ST_UPDATE,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic load;
      logic div_step;
      logic mul_step;
      logic update;
      logic result_load;
   } cmd_type;

   typedef struct packed {
      logic nr_zero;
   } status_type;

endpackage

// ===== sv/mie_dp.sv =====
// datapath: restoring divider, bit-serial modular multiply and coefficient update
// depends on mie_pkg for the command and status structs
module mie_dp #(
   parameter int WORD_BITS = 31
) (
   input  logic                   clock,
   input  mie_pkg::cmd_type       cmd,
   input  logic [WORD_BITS-1:0]   req_value,
   input  logic [WORD_BITS-1:0]   req_modulus,
   output mie_pkg::status_type    status,
   output logic [WORD_BITS-1:0]   t_out
);

   localparam int W = WORD_BITS;

   logic [W-1:0] n_ff, t_ff, nt_ff, nr_ff, dvd_ff, acc_ff;
   logic [W:0]   p_ff;
   logic         qbit_ff;

   logic [W:0]   p_shift, p_next;
   logic         q_ge;
   logic [W:0]   dbl, dbl_red, sum, sum_red;
   logic [W-1:0] t_new;

   // one restoring division step, quotient bits shift into the dividend register
   always_comb begin
      p_shift = {p_ff[W-1:0], dvd_ff[W-1]};
      q_ge    = (p_shift >= {1'b0, nr_ff});
      p_next  = q_ge ? (p_shift - {1'b0, nr_ff}) : p_shift;
   end

   // horner step of q * nt mod n, using the registered quotient bit from the previous divider step
   always_comb begin
      dbl     = {acc_ff, 1'b0};
      dbl_red = (dbl >= {1'b0, n_ff}) ? (dbl - {1'b0, n_ff}) : dbl;
      sum     = {1'b0, dbl_red[W-1:0]} + (qbit_ff ? {1'b0, nt_ff} : {(W+1){1'b0}});
      sum_red = (sum >= {1'b0, n_ff}) ? (sum - {1'b0, n_ff}) : sum;
   end

   // t - q*nt mod n
   always_comb begin
      if (t_ff >= acc_ff) begin
         t_new = t_ff - acc_ff;
      end else begin
         t_new = n_ff - (acc_ff - t_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         n_ff    <= req_modulus;
         t_ff    <= '0;
         nt_ff   <= (req_modulus > {{(W-1){1'b0}}, 1'b1}) ? {{(W-1){1'b0}}, 1'b1} : '0;
         nr_ff   <= (req_modulus == '0) ? '0 : req_value;
         dvd_ff  <= req_modulus;
         p_ff    <= '0;
         acc_ff  <= '0;
         qbit_ff <= 1'b0;
      end else if (cmd.update) begin
         t_ff   <= nt_ff;
         nt_ff  <= t_new;
         nr_ff  <= p_ff[W-1:0];
         dvd_ff <= nr_ff;
         p_ff   <= '0;
         acc_ff <= '0;
      end else begin
         if (cmd.div_step) begin
            p_ff    <= p_next;
            dvd_ff  <= {dvd_ff[W-2:0], q_ge};
            qbit_ff <= q_ge;
         end
         if (cmd.mul_step) begin
            acc_ff <= sum_red[W-1:0];
         end
      end
   end

   assign status.nr_zero = (nr_ff == '0);
   assign t_out          = t_ff;

endmodule

// ===== sv/mie_ctrl.sv =====
// controller state machine for the modular inverse block
// depends on mie_pkg for the state enum and command / status structs
module mie_ctrl #(
   parameter int WORD_BITS = 31
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic                 out_free,
   input  mie_pkg::status_type  status,
   output mie_pkg::cmd_type     cmd
);

   localparam int CW = $clog2(WORD_BITS + 1);

   mie_pkg::state_type state_ff, state_in;
   logic [CW-1:0]      count_ff, count_in;
   logic               count_last;

   assign count_last = (count_ff == CW'(WORD_BITS));

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mie_pkg::ST_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      case (state_ff)
         mie_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = mie_pkg::ST_CHECK;
            end
         end
         mie_pkg::ST_CHECK: begin
            count_in = '0;
            state_in = status.nr_zero ? mie_pkg::ST_DONE : mie_pkg::ST_ITER;
         end
         mie_pkg::ST_ITER: begin
            count_in = count_ff + 1'b1;
            if (count_last) begin
               state_in = mie_pkg::ST_UPDATE;
            end
         end
         mie_pkg::ST_UPDATE: begin
            state_in = mie_pkg::ST_CHECK;
         end
         mie_pkg::ST_DONE: begin
            if (out_free) begin
               state_in = mie_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = mie_pkg::ST_IDLE;
         end
      endcase
   end

   // outputs
   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      case (state_ff)
         mie_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            cmd.load  = req_valid;
         end
         mie_pkg::ST_CHECK: begin
         end
         mie_pkg::ST_ITER: begin
            cmd.div_step = !count_last;
            cmd.mul_step = (count_ff != '0);
         end
         mie_pkg::ST_UPDATE: begin
            cmd.update = 1'b1;
         end
         mie_pkg::ST_DONE: begin
            cmd.result_load = out_free;
         end
         default: begin
         end
      endcase
   end

endmodule

// ===== sv/modular_inverse_ext_euclid.sv =====
// channel   ports                                   direction
// req       req_valid, req_stall, req_value, req_modulus   in
// rsp       rsp_valid, rsp_stall, rsp_inverse_out         out
//
// each quotient step passes through the check state, the iterate state, in which the
// one-bit-per-cycle divider and the modular multiplier run overlapped, and one coefficient update
// the result is loaded once the check state finds the remainder zero, and the block
// returns to idle before it accepts the next request
// reset is synchronous and clears the controller and the result valid flag
// a result that finds an earlier one still waiting on rsp_stall holds the block in its done
// state; the result register frees the datapath as soon as it takes the result
module modular_inverse_ext_euclid #(
   parameter int WORD_BITS = 31
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [WORD_BITS-1:0] req_value,
   input  logic [WORD_BITS-1:0] req_modulus,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [WORD_BITS-1:0] rsp_inverse_out
);

`include "modular_inverse_ext_euclid_macros.svh"

   mie_pkg::cmd_type    cmd;
   mie_pkg::status_type status;
   logic [WORD_BITS-1:0] t_out;
   logic                 out_free;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic [WORD_BITS-1:0] rsp_inverse_ff;

   assign out_free = !rsp_valid_ff || !rsp_stall;

   mie_ctrl #(
      .WORD_BITS(WORD_BITS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .out_free  (out_free),
      .status    (status),
      .cmd       (cmd)
   );

   mie_dp #(
      .WORD_BITS(WORD_BITS)
   ) u_dp (
      .clock       (clock),
      .cmd         (cmd),
      .req_value   (req_value),
      .req_modulus (req_modulus),
      .status      (status),
      .t_out       (t_out)
   );

   always_comb begin
      if (cmd.result_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_stall) begin
         rsp_valid_in = rsp_valid_ff;
      end else begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.result_load) begin
         rsp_inverse_ff <= t_out;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_inverse_out = rsp_inverse_ff;

   // an accepted transaction keeps the input side busy on the next cycle
   `MIE_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && !req_stall, req_stall)
   // a result is only loaded into a free output register
   `MIE_ASSERT_NOW(a_load_into_free, clock, reset, cmd.result_load,
                   !rsp_valid_ff || !rsp_stall)
   // loading a result always presents it
   `MIE_ASSERT_NEXT(a_load_shows_valid, clock, reset, cmd.result_load, rsp_valid)
   // a taken result with nothing new behind it leaves the output empty
   `MIE_ASSERT_NEXT(a_taken_clears, clock, reset,
                    rsp_valid && !rsp_stall && !cmd.result_load, !rsp_valid)

endmodule
